[rtl/first_fit_heap_allocator_assert.svh]
// Assertion macros shared by the allocator RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define FFHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
// No dependencies; used by the controller, datapath and top level.
package ffha_pkg;

	localparam int HEAP_MAX_BYTES = 1024;
	localparam int ALIGN_BYTES    = 8;
	localparam int HEADER_BYTES   = 16;

	localparam int SLOTS    = HEAP_MAX_BYTES / ALIGN_BYTES;
	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int ALIGN_SH = $clog2(ALIGN_BYTES);
	localparam int SIZE_W   = 11;
	localparam int REQ_W    = 11;
	localparam int OFF_W    = 10;
	localparam int ADJ_W    = REQ_W + 1;
	localparam int CMP_W    = ADJ_W + 1;
	localparam int STEP_W   = $clog2(HEAP_MAX_BYTES) + 1;

	// request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes
	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
	localparam logic [1:0] ST_NO_FIT    = 2'd2;
	localparam logic [1:0] ST_FREED     = 2'd3;

	// one block header: data size, link to next free block, link valid
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [SLOT_W-1:0] next;
		logic              link;
	} hdr_t;

	// controller to datapath
	typedef struct packed {
		logic       init_hdr;
		logic       start_alloc;
		logic       start_free;
		logic       rd_curr;
		logic       advance;
		logic       take;
		logic       wr_split;
		logic       wr_curr;
		logic       rd_prev;
		logic       wr_prev;
		logic       set_head;
		logic       rd_free;
		logic       wr_free;
		logic       result;
		logic [1:0] res_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_zero;
		logic have_curr;
		logic steps_done;
		logic fits;
		logic split;
		logic have_prev;
		logic free_ok;
	} stat_t;

endpackage

[rtl/ffha_dp.sv]
// Datapath of the allocator: header memory, free-list head, walk registers
// and result registers. Depends on ffha_pkg; driven by ffha_ctrl commands.
`include "first_fit_heap_allocator_assert.svh"

module ffha_dp import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic [SIZE_W-1:0] heap_bytes,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [OFF_W-1:0]  free_offset,
	output logic              done,
	output logic [OFF_W-1:0]  data_offset,
	output logic [1:0]        status
);

	// header store, one entry per aligned slot
	hdr_t hdr_mem_q [SLOTS];
	hdr_t rdata_q;

	logic [SLOT_W-1:0] head_slot_q;
	logic              head_valid_q;
	logic [SLOT_W-1:0] curr_q;
	logic              have_curr_q;
	logic [SLOT_W-1:0] prev_q;
	logic              have_prev_q;
	logic [STEP_W-1:0] steps_q;
	logic [ADJ_W-1:0]  adj_q;
	logic [SLOT_W-1:0] nxt_q;
	logic              nxt_ok_q;
	logic [SLOT_W-1:0] split_slot_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SLOT_W-1:0] free_slot_q;
	logic              free_ok_q;
	logic              done_q;
	logic [OFF_W-1:0]  data_offset_q;
	logic [1:0]        status_q;

	logic [SIZE_W-1:0] span;
	logic [SIZE_W-1:0] init_size;
	logic [ADJ_W-1:0]  adj_c;
	logic [CMP_W-1:0]  size_c;
	logic [CMP_W-1:0]  split_need;
	logic [CMP_W-1:0]  split_at;
	logic [CMP_W-1:0]  rem_c;
	logic              fits_c;
	logic              split_c;
	logic [OFF_W-1:0]  free_hdr;
	logic              free_ok_c;
	logic [OFF_W-1:0]  curr_off;

	logic              we;
	logic [SLOT_W-1:0] waddr;
	hdr_t              wdata;
	logic              re;
	logic [SLOT_W-1:0] raddr;

	// heap span and the size of the single block after a rebuild
	assign span      = (heap_bytes > SIZE_W'(HEAP_MAX_BYTES)) ? SIZE_W'(HEAP_MAX_BYTES)
		: heap_bytes;
	assign init_size = (span >= SIZE_W'(HEADER_BYTES)) ? span - SIZE_W'(HEADER_BYTES)
		: '0;

	// round the request up to the alignment
	assign adj_c = (ADJ_W'(request_bytes) + ADJ_W'(ALIGN_BYTES - 1))
		& ~ADJ_W'(ALIGN_BYTES - 1);

	// fit and split test on the header just read
	assign size_c     = CMP_W'(rdata_q.size);
	assign fits_c     = size_c >= CMP_W'(adj_q);
	assign split_need = CMP_W'(adj_q) + CMP_W'(HEADER_BYTES + ALIGN_BYTES);
	assign split_at   = CMP_W'({curr_q, {ALIGN_SH{1'b0}}}) + CMP_W'(HEADER_BYTES)
		+ CMP_W'(adj_q);
	assign split_c    = (size_c >= split_need) && (split_at < CMP_W'(HEAP_MAX_BYTES));
	assign rem_c      = size_c - CMP_W'(adj_q) - CMP_W'(HEADER_BYTES);

	// free range check
	assign free_hdr  = free_offset - OFF_W'(HEADER_BYTES);
	assign free_ok_c = (free_offset >= OFF_W'(HEADER_BYTES))
		&& (SIZE_W'(free_hdr) < span);

	assign curr_off = OFF_W'({curr_q, {ALIGN_SH{1'b0}}}) + OFF_W'(HEADER_BYTES);

	// status toward the controller
	assign stat.req_zero   = (request_bytes == '0);
	assign stat.have_curr  = have_curr_q;
	assign stat.steps_done = (steps_q == STEP_W'(HEAP_MAX_BYTES));
	assign stat.fits       = fits_c;
	assign stat.split      = split_c;
	assign stat.have_prev  = have_prev_q;
	assign stat.free_ok    = free_ok_q;

	// select the memory write
	always_comb begin
		we    = 1'b1;
		waddr = '0;
		wdata = '0;
		priority if (cmd.init_hdr) begin
			wdata.size = init_size;
		end else if (cmd.wr_split) begin
			waddr = split_slot_q;
			wdata = '{size: rem_q, next: rdata_q.next, link: rdata_q.link};
		end else if (cmd.wr_curr) begin
			waddr = curr_q;
			wdata = '{size: SIZE_W'(adj_q), next: rdata_q.next, link: rdata_q.link};
		end else if (cmd.wr_prev) begin
			waddr = prev_q;
			wdata = '{size: rdata_q.size, next: nxt_q, link: nxt_ok_q};
		end else if (cmd.wr_free) begin
			waddr = free_slot_q;
			wdata = '{size: rdata_q.size, next: head_slot_q, link: head_valid_q};
		end else begin
			we = 1'b0;
		end
	end

	// select the memory read
	always_comb begin
		re    = 1'b1;
		raddr = curr_q;
		priority if (cmd.rd_curr) begin
			raddr = curr_q;
		end else if (cmd.rd_prev) begin
			raddr = prev_q;
		end else if (cmd.rd_free) begin
			raddr = free_slot_q;
		end else begin
			re = 1'b0;
		end
	end

	// header memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			hdr_mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= hdr_mem_q[raddr];
		end
	end

	// free-list head and walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot_q  <= '0;
			head_valid_q <= 1'b1;
			have_curr_q  <= 1'b0;
			have_prev_q  <= 1'b0;
			steps_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= cmd.result;
			if (cmd.init_hdr) begin
				head_slot_q  <= '0;
				head_valid_q <= 1'b1;
			end
			if (cmd.start_alloc) begin
				have_curr_q <= head_valid_q;
				have_prev_q <= 1'b0;
				steps_q     <= '0;
			end
			if (cmd.advance) begin
				have_curr_q <= rdata_q.link;
				have_prev_q <= 1'b1;
				steps_q     <= steps_q + 1'b1;
			end
			if (cmd.set_head) begin
				head_slot_q  <= nxt_q;
				head_valid_q <= nxt_ok_q;
			end
			if (cmd.wr_free) begin
				head_slot_q  <= free_slot_q;
				head_valid_q <= 1'b1;
			end
		end
	end

	// walk payload and result payload
	always_ff @(posedge clk) begin
		if (cmd.start_alloc) begin
			adj_q  <= adj_c;
			curr_q <= head_slot_q;
		end
		if (cmd.advance) begin
			prev_q <= curr_q;
			curr_q <= rdata_q.next;
		end
		if (cmd.take) begin
			split_slot_q <= split_at[ALIGN_SH +: SLOT_W];
			rem_q        <= SIZE_W'(rem_c);
			nxt_q        <= split_c ? split_at[ALIGN_SH +: SLOT_W] : rdata_q.next;
			nxt_ok_q     <= split_c ? 1'b1 : rdata_q.link;
		end
		if (cmd.start_free) begin
			free_slot_q <= free_hdr[ALIGN_SH +: SLOT_W];
			free_ok_q   <= free_ok_c;
		end
		if (cmd.result) begin
			status_q      <= cmd.res_status;
			data_offset_q <= (cmd.res_status == ST_ALLOCATED) ? curr_off : '0;
		end
	end

	assign done        = done_q;
	assign data_offset = data_offset_q;
	assign status      = status_q;

	`FFHA_ASSERT_IMP(a_offset_zero, done_q && (status_q != ST_ALLOCATED),
		data_offset_q == '0, "data offset not zero on a failed or free request")
	`FFHA_ASSERT_NXT(a_free_head, cmd.wr_free, head_valid_q,
		"free list head not valid after a free")

endmodule

[rtl/ffha_ctrl.sv]
// Controller state machine of the allocator: sequences the list walk,
// header updates and frees. Depends on ffha_pkg; drives ffha_dp.
`include "first_fit_heap_allocator_assert.svh"

module ffha_ctrl import ffha_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  op,
	input  logic  cfg_wr,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy
);

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_A_RD   = 4'd2;
	localparam logic [3:0] S_A_EVAL = 4'd3;
	localparam logic [3:0] S_A_SPL  = 4'd4;
	localparam logic [3:0] S_A_CUR  = 4'd5;
	localparam logic [3:0] S_A_HEAD = 4'd6;
	localparam logic [3:0] S_P_RD   = 4'd7;
	localparam logic [3:0] S_P_WR   = 4'd8;
	localparam logic [3:0] S_F_RD   = 4'd9;
	localparam logic [3:0] S_F_WR   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_hdr = 1'b1;
				state_d      = S_IDLE;
			end
			S_IDLE: begin
				priority if (cfg_wr) begin
					state_d = S_INIT;
				end else if (start && (op == OP_FREE)) begin
					cmd.start_free = 1'b1;
					state_d        = S_F_RD;
				end else if (start && stat.req_zero) begin
					cmd.result     = 1'b1;
					cmd.res_status = ST_BAD_SIZE;
				end else if (start) begin
					cmd.start_alloc = 1'b1;
					state_d         = S_A_RD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_A_RD: begin
				if (!stat.have_curr || stat.steps_done) begin
					cmd.result     = 1'b1;
					cmd.res_status = ST_NO_FIT;
					state_d        = S_IDLE;
				end else begin
					cmd.rd_curr = 1'b1;
					state_d     = S_A_EVAL;
				end
			end
			S_A_EVAL: begin
				priority if (!stat.fits) begin
					cmd.advance = 1'b1;
					state_d     = S_A_RD;
				end else if (stat.split) begin
					cmd.take = 1'b1;
					state_d  = S_A_SPL;
				end else begin
					cmd.take = 1'b1;
					state_d  = stat.have_prev ? S_P_RD : S_A_HEAD;
				end
			end
			S_A_SPL: begin
				cmd.wr_split = 1'b1;
				state_d      = S_A_CUR;
			end
			S_A_CUR: begin
				cmd.wr_curr = 1'b1;
				state_d     = stat.have_prev ? S_P_RD : S_A_HEAD;
			end
			S_A_HEAD: begin
				cmd.set_head   = 1'b1;
				cmd.result     = 1'b1;
				cmd.res_status = ST_ALLOCATED;
				state_d        = S_IDLE;
			end
			S_P_RD: begin
				cmd.rd_prev = 1'b1;
				state_d     = S_P_WR;
			end
			S_P_WR: begin
				cmd.wr_prev    = 1'b1;
				cmd.result     = 1'b1;
				cmd.res_status = ST_ALLOCATED;
				state_d        = S_IDLE;
			end
			S_F_RD: begin
				if (stat.free_ok) begin
					cmd.rd_free = 1'b1;
					state_d     = S_F_WR;
				end else begin
					cmd.result     = 1'b1;
					cmd.res_status = ST_FREED;
					state_d        = S_IDLE;
				end
			end
			S_F_WR: begin
				cmd.wr_free    = 1'b1;
				cmd.result     = 1'b1;
				cmd.res_status = ST_FREED;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// hold state; reset writes the first header before the first request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`FFHA_ASSERT_IMP(a_one_write,
		1'b1,
		$onehot0({cmd.init_hdr, cmd.wr_split, cmd.wr_curr, cmd.wr_prev, cmd.wr_free}),
		"more than one header write in a cycle")
	`FFHA_ASSERT_IMP(a_prev_order, state_q == S_P_WR, $past(state_q) == S_P_RD,
		"previous header written without a read")
	`FFHA_ASSERT_NXT(a_result_ends, cmd.result, state_q == S_IDLE,
		"controller not idle after a result")

endmodule

[rtl/first_fit_heap_allocator.sv]
// First-fit heap allocator: one request at a time; a bad-size result follows in the
// cycle after accept. A valid free reads and rewrites one header; the walk reads one
// header at a time from the header memory (one read and one write port). done pulses one
// cycle per result. Reset and a heap_bytes write while idle pass through an init state
// (busy high) that writes the first header; the head resets to slot 0.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [REQ_W-1:0]  request_bytes,
	input  logic [OFF_W-1:0]  free_offset,
	output logic              done,
	output logic [OFF_W-1:0]  data_offset,
	output logic [1:0]        status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam logic REG_HEAP_BYTES = 1'b0;

	logic [SIZE_W-1:0] heap_bytes_q;
	logic              cfg_wr;
	cmd_t              cmd;
	stat_t             stat;

	// register write strobe
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HEAP_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_bytes_q <= SIZE_W'(HEAP_MAX_BYTES);
		end else if (cfg_wr) begin
			heap_bytes_q <= pwdata[SIZE_W-1:0];
		end
	end

	// register readback
	assign prdata = (paddr[2] == REG_HEAP_BYTES) ? 32'(heap_bytes_q) : '0;

	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.cfg_wr (cfg_wr),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	ffha_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.heap_bytes    (heap_bytes_q),
		.request_bytes (request_bytes),
		.free_offset   (free_offset),
		.done          (done),
		.data_offset   (data_offset),
		.status        (status)
	);

endmodule
